/* hw/rtl/cmu_pkg.sv */
// Package for the CPU and memory utilization core.
// Holds the sample and result types, widths, and the controller-datapath command set.
// No dependencies.
package cmu_pkg;

    // Field widths.
    localparam int TimeW  = 48;
    localparam int CntW   = 8;
    localparam int PctW   = 7;

    // Span is an uptime delta times the CPU count.
    localparam int SpanW  = TimeW + CntW;
    // Dividend is a part times 100, and the part stays below 2^56.
    localparam int NumW   = SpanW + 7;
    // Divisor is the whole shifted up by the top quotient bit.
    localparam int QuoTop = PctW - 1;
    localparam int DenW   = SpanW + QuoTop;

    // The quotient is below 100, so the divider produces seven bits.
    localparam int DivSteps = PctW;
    localparam int StepW    = $clog2(DivSteps);

    localparam logic [PctW-1:0] PctZero = '0;
    localparam logic [PctW-1:0] PctFull = PctW'(100);

    // One monitoring sample.
    typedef struct packed {
        logic [TimeW-1:0] sys_uptime;
        logic [TimeW-1:0] idle_ms;
        logic [CntW-1:0]  cpu_count;
        logic             cpu_sample_ok;
        logic [TimeW-1:0] mem_total;
        logic [TimeW-1:0] mem_free;
    } cmu_in_t;

    // One result.
    typedef struct packed {
        logic [PctW-1:0] cpu_busy_pct;
        logic [PctW-1:0] mem_used_pct;
    } cmu_out_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_SPAN,
        DP_PART,
        DP_SCALE_A,
        DP_SCALE_B,
        DP_DIV_STEP,
        DP_SAVE,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_mem;
    } cmu_cmd_t;

    typedef struct packed {
        logic skip_div;
    } cmu_status_t;

endpackage

/* hw/rtl/cmu_in_if.sv */
// Sample request channel: valid, ready and one monitoring sample.
// Depends on cmu_pkg.
interface cmu_in_if;
    import cmu_pkg::*;

    logic    valid;
    logic    ready;
    cmu_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/cmu_out_if.sv */
// Result request channel: valid, ready and one pair of percentages.
// Depends on cmu_pkg.
interface cmu_out_if;
    import cmu_pkg::*;

    logic     valid;
    logic     ready;
    cmu_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/cpu_and_memory_utilization_core.sv */
// Top level of the CPU and memory utilization core; joins controller and datapath.
// Depends on cmu_pkg, cmu_in_if, cmu_out_if, cmu_ctrl and cmu_datapath.
//
// Each accepted sample yields one result: the CPU busy percentage over the interval
// since the previous valid CPU sample, and the memory used percentage, both floored.
// From acceptance to result, a sample passes through the capture, the span multiply,
// then for each percentage two setup steps, a third setup step and a restoring
// division on the single shared divider (both skipped when the result is forced to
// 0 or 100) and a save step, and finally the load of the output register. Loading
// waits for as long as the previous result is still held and not taken. The next
// sample is accepted in the cycle after the result is loaded, while that result may
// still wait to be taken.
module cpu_and_memory_utilization_core (
    input logic       clk,
    input logic       rst_n,
    cmu_in_if.sink    in_ch,
    cmu_out_if.source out_ch
);
    import cmu_pkg::*;

    cmu_cmd_t    cmd;
    cmu_status_t status;

    // Sequencer.
    cmu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Arithmetic and storage.
    cmu_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_ch.data),
        .cmd    (cmd),
        .status (status),
        .result (out_ch.data)
    );

`ifndef SYNTH
    // Once a request is taken, no further request is taken on the next edge.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while a request is in progress");

    // Percentages never exceed 100.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.data.cpu_busy_pct <= PctFull)
                          && (out_ch.data.mem_used_pct <= PctFull)))
        else $error("percentage out of range");

    // A new result appears only at the end of a request's processing.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(!in_ch.ready))
        else $error("result published while idle");
`endif

endmodule

/* hw/rtl/cmu_ctrl.sv */
// Controller state machine for the utilization core.
// Sequences capture, span, the two shared divisions and the output register.
// Depends on cmu_pkg.
module cmu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cmu_pkg::cmu_cmd_t    cmd,
    input  cmu_pkg::cmu_status_t status
);
    import cmu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_PART,
        S_SCALE_A,
        S_SCALE_B,
        S_DIV,
        S_SAVE,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic             mem_reg;
    logic [StepW-1:0] step_reg;
    logic             out_valid_reg;
    logic             can_publish;

    // The output register is free when empty or being drained this cycle.
    assign can_publish = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;

    // Command decode from the current state.
    always_comb
    begin
        cmd.op      = DP_NOP;
        cmd.sel_mem = mem_reg;
        case (state_reg)
            S_IDLE:    cmd.op = in_valid ? DP_CAPTURE : DP_NOP;
            S_SPAN:    cmd.op = DP_SPAN;
            S_PART:    cmd.op = DP_PART;
            S_SCALE_A: cmd.op = DP_SCALE_A;
            S_SCALE_B: cmd.op = DP_SCALE_B;
            S_DIV:     cmd.op = DP_DIV_STEP;
            S_SAVE:    cmd.op = DP_SAVE;
            S_DONE:    cmd.op = can_publish ? DP_PUBLISH : DP_NOP;
            default:   cmd.op = DP_NOP;
        endcase
    end

    // State, phase, step counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mem_reg       <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && can_publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mem_reg   <= 1'b0;
                        state_reg <= S_SPAN;
                    end
                end
                S_SPAN:
                begin
                    state_reg <= S_PART;
                end
                S_PART:
                begin
                    state_reg <= S_SCALE_A;
                end
                S_SCALE_A:
                begin
                    // A forced result of 0 or 100 needs no division.
                    state_reg <= status.skip_div ? S_SAVE : S_SCALE_B;
                end
                S_SCALE_B:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == StepW'(DivSteps - 1))
                    begin
                        state_reg <= S_SAVE;
                    end
                end
                S_SAVE:
                begin
                    if (!mem_reg)
                    begin
                        mem_reg   <= 1'b1;
                        state_reg <= S_PART;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (can_publish)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/cmu_datapath.sv */
// Datapath for the utilization core: sample history, span multiplier,
// shared seven-step restoring divider and the result register. Depends on cmu_pkg.
module cmu_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmu_pkg::cmu_in_t     sample,
    input  cmu_pkg::cmu_cmd_t    cmd,
    output cmu_pkg::cmu_status_t status,
    output cmu_pkg::cmu_out_t    result
);
    import cmu_pkg::*;

    // History of the previous valid CPU sample.
    logic [TimeW-1:0] last_uptime_reg;
    logic [TimeW-1:0] last_idle_reg;
    logic             have_last_reg;

    // Captured sample values.
    logic [TimeW-1:0] dt_reg;
    logic [TimeW-1:0] didle_reg;
    logic [CntW-1:0]  ncpu_reg;
    logic             cpu_go_reg;
    logic [TimeW-1:0] total_reg;
    logic [TimeW-1:0] free_reg;

    // Division operands and working registers.
    logic [SpanW-1:0] span_reg;
    logic [SpanW-1:0] part_reg;
    logic [SpanW-1:0] whole_reg;
    logic             force0_reg;
    logic             force100_reg;
    logic [NumW-1:0]  num_reg;
    logic [DenW-1:0]  den_reg;
    logic [PctW-1:0]  quo_reg;
    logic [PctW-1:0]  cpu_pct_reg;
    logic [PctW-1:0]  mem_pct_reg;
    logic [PctW-1:0]  out_cpu_reg;
    logic [PctW-1:0]  out_mem_reg;

    logic             cpu_go_next;
    logic [TimeW-1:0] didle_next;
    logic [SpanW-1:0] didle_ext;
    logic             div_fits;
    logic [PctW-1:0]  pct_next;

    // The CPU percentage is computed only with a valid sample, history, elapsed time and CPUs.
    assign cpu_go_next = sample.cpu_sample_ok && have_last_reg
                         && (sample.sys_uptime > last_uptime_reg)
                         && (sample.cpu_count != '0);
    // Idle time going backwards counts as no idle time.
    assign didle_next  = (sample.idle_ms > last_idle_reg)
                         ? (sample.idle_ms - last_idle_reg) : '0;
    assign didle_ext   = SpanW'(didle_reg);
    assign div_fits    = (num_reg >= NumW'(den_reg));
    assign pct_next    = force0_reg ? PctZero : (force100_reg ? PctFull : quo_reg);

    assign status.skip_div     = force0_reg || force100_reg;
    assign result.cpu_busy_pct = out_cpu_reg;
    assign result.mem_used_pct = out_mem_reg;

    // History update on each accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_uptime_reg <= '0;
            last_idle_reg   <= '0;
            have_last_reg   <= 1'b0;
        end
        else if (cmd.op == DP_CAPTURE)
        begin
            if (sample.cpu_sample_ok)
            begin
                last_uptime_reg <= sample.sys_uptime;
                last_idle_reg   <= sample.idle_ms;
                have_last_reg   <= 1'b1;
            end
            else
            begin
                have_last_reg <= 1'b0;
            end
        end
    end

    // Payload registers, one operation per cycle.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_CAPTURE:
            begin
                dt_reg     <= sample.sys_uptime - last_uptime_reg;
                didle_reg  <= didle_next;
                ncpu_reg   <= sample.cpu_count;
                cpu_go_reg <= cpu_go_next;
                total_reg  <= sample.mem_total;
                free_reg   <= sample.mem_free;
            end
            DP_SPAN:
            begin
                span_reg <= SpanW'(dt_reg) * SpanW'(ncpu_reg);
            end
            DP_PART:
            begin
                if (cmd.sel_mem)
                begin
                    whole_reg    <= SpanW'(total_reg);
                    part_reg     <= SpanW'(total_reg - free_reg);
                    force0_reg   <= (total_reg == '0) || (free_reg >= total_reg);
                    force100_reg <= (free_reg == '0);
                end
                else
                begin
                    // Idle delta is clamped to the span.
                    whole_reg    <= span_reg;
                    part_reg     <= (didle_ext > span_reg) ? '0 : (span_reg - didle_ext);
                    force0_reg   <= !cpu_go_reg;
                    force100_reg <= (didle_reg == '0);
                end
            end
            DP_SCALE_A:
            begin
                // part * 100 = part * 64 + part * 32 + part * 4, in two adds.
                num_reg <= (NumW'(part_reg) << 6) + (NumW'(part_reg) << 5);
                den_reg <= DenW'(whole_reg) << QuoTop;
                quo_reg <= '0;
            end
            DP_SCALE_B:
            begin
                num_reg <= num_reg + (NumW'(part_reg) << 2);
            end
            DP_DIV_STEP:
            begin
                // One quotient bit per step, most significant first.
                if (div_fits)
                begin
                    num_reg <= num_reg - NumW'(den_reg);
                end
                quo_reg <= {quo_reg[PctW-2:0], div_fits};
                den_reg <= den_reg >> 1;
            end
            DP_SAVE:
            begin
                if (cmd.sel_mem)
                begin
                    mem_pct_reg <= pct_next;
                end
                else
                begin
                    cpu_pct_reg <= pct_next;
                end
            end
            DP_PUBLISH:
            begin
                out_cpu_reg <= cpu_pct_reg;
                out_mem_reg <= mem_pct_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule
